/* rtl/core/tlb_address_translation_assert.svh */
// assertion macros for the tlb address translation block
`ifndef TLB_ADDRESS_TRANSLATION_ASSERT_SVH
`define TLB_ADDRESS_TRANSLATION_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define TAT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TAT_ASSERT_NORST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TAT_ASSERT(label, prop, msg)
`define TAT_ASSERT_NORST(label, prop, msg)
`endif

`endif

/* rtl/core/tat_pkg.sv */
package tat_pkg;

  localparam int TLB_ENTRIES = 4;
  localparam int IDX_W       = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

  localparam int VA_W        = 16;
  localparam int PAGE_W      = 4;
  localparam int OFFSET_W    = 12;
  localparam int FRAME_W     = 6;
  localparam int PA_W        = 17;
  localparam int HIT_IDX_W   = 2;
  localparam int FRAME_SHIFT = 10;

  localparam logic [PAGE_W-1:0]  PAGE_XOR   = 4'hA;
  localparam logic [FRAME_W-1:0] FRAME_BIAS = 6'd13;

  typedef struct packed {
    logic               hit;
    logic [IDX_W-1:0]   idx;
    logic [FRAME_W-1:0] frame;
  } lookup_t;

  // frame for a page that misses, modulo 64 by truncation to FRAME_W bits
  function automatic logic [FRAME_W-1:0] frame_of_page(input logic [PAGE_W-1:0] page);
    logic [FRAME_W-1:0] a;
    logic [FRAME_W-1:0] b;
    a = FRAME_W'(page ^ PAGE_XOR);
    b = FRAME_W'({page, 2'b00});
    return a + b + FRAME_BIAS;
  endfunction

endpackage

/* rtl/core/tat_tlb.sv */
`include "tlb_address_translation_assert.svh"

module tat_tlb import tat_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [PAGE_W-1:0] page,
  output lookup_t           res
);

  logic [TLB_ENTRIES-1:0] valid;
  logic [PAGE_W-1:0]      pages  [TLB_ENTRIES];
  logic [FRAME_W-1:0]     frames [TLB_ENTRIES];
  logic [IDX_W-1:0]       ptr;
  logic [IDX_W-1:0]       ptr_next;

  logic [TLB_ENTRIES-1:0] match;
  logic                   hit;
  logic [IDX_W-1:0]       idx;
  logic [FRAME_W-1:0]     miss_frame;

  always_comb begin
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      match[i] = valid[i] && (pages[i] == page);
    end
  end

  // lowest matching entry wins
  always_comb begin
    hit = 1'b0;
    idx = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit = 1'b1;
        idx = IDX_W'(i);
      end
    end
  end

  assign miss_frame = frame_of_page(page);
  assign ptr_next   = (ptr == IDX_W'(TLB_ENTRIES - 1)) ? '0 : ptr + IDX_W'(1);

  assign res.hit   = hit;
  assign res.idx   = idx;
  assign res.frame = hit ? frames[idx] : miss_frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      ptr   <= '0;
    end else if (en) begin
      if (hit) begin
        if (idx == ptr) begin
          ptr <= ptr_next;
        end
      end else begin
        valid[ptr] <= 1'b1;
        ptr        <= ptr_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && !hit) begin
      pages[ptr]  <= page;
      frames[ptr] <= miss_frame;
    end
  end

  `TAT_ASSERT(a_no_dup_match, $onehot0(match), "tlb holds the same page twice")
  `TAT_ASSERT(a_valid_sticky, !$past(rst) |-> ((valid & $past(valid)) == $past(valid)), "tlb entry lost its valid bit")
  `TAT_ASSERT(a_miss_fills, (en && !hit) |=> valid[$past(ptr)], "miss did not fill the replaced entry")
  `TAT_ASSERT_NORST(a_reset_clears, rst |=> (valid == '0) && (ptr == '0), "reset did not clear the tlb")

endmodule

/* rtl/core/tlb_address_translation.sv */
// tlb address translation
// input channel: addr_valid / addr_stall carry one 16-bit virtual address per item;
//   bits 15..12 are the page number, bits 11..0 the page offset
// output channel: result_valid / result_stall carry physical_address, tlb_hit
//   and hit_entry for each item, in input order, one result per item
// an item is taken at a clock edge with valid high and stall low
// path: an item taken from the input channel sits in the input register, is looked up
//   in the four-entry tlb and lands in the result register
// throughput: one item per cycle while result_stall is low; the tlb compare, the miss
//   frame and the replacement update all sit between the two registers
// a miss writes the page and its computed frame at the round-robin pointer
// reset (rst, synchronous) clears all entry valid bits, the pointer and both
//   pipeline valids; tlb contents are not cleared
// when result_stall is high the result register holds, the input register
//   keeps its item and addr_stall rises once it is full; nothing is dropped
module tlb_address_translation import tat_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                addr_valid,
  output logic                addr_stall,
  input  logic [VA_W-1:0]     virtual_address,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [PA_W-1:0]     physical_address,
  output logic                tlb_hit,
  output logic [HIT_IDX_W-1:0] hit_entry
);

  logic            s1_valid;
  logic [VA_W-1:0] s1_va;
  logic            adv;
  lookup_t         lk;

  assign adv        = s1_valid && (!result_valid || !result_stall);
  assign addr_stall = s1_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!addr_stall) begin
      s1_valid <= addr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (addr_valid && !addr_stall) begin
      s1_va <= virtual_address;
    end
  end

  tat_tlb u_tlb (
    .clk  (clk),
    .rst  (rst),
    .en   (adv),
    .page (s1_va[VA_W-1 -: PAGE_W]),
    .res  (lk)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      physical_address <= (PA_W'(lk.frame) << FRAME_SHIFT) + PA_W'(s1_va[OFFSET_W-1:0]);
      tlb_hit          <= lk.hit;
      hit_entry        <= lk.hit ? HIT_IDX_W'(lk.idx) : '0;
    end
  end

endmodule
